// ===== rtl/point_table_nearest_bbox_unit_assert.svh =====
// Assertion macros for the point table checker.
`ifndef POINT_TABLE_NEAREST_BBOX_UNIT_ASSERT_SVH
`define POINT_TABLE_NEAREST_BBOX_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PTNB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTNB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ptnb_pkg.sv =====
`timescale 1ns / 1ps
package ptnb_pkg;

  typedef logic [2:0] op_t;
  localparam op_t OP_ADD     = 3'd0;
  localparam op_t OP_REMOVE  = 3'd1;
  localparam op_t OP_CLEAR   = 3'd2;
  localparam op_t OP_NEAREST = 3'd3;
  localparam op_t OP_BBOX    = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ===== rtl/ptnb_ram.sv =====
`timescale 1ns / 1ps
module ptnb_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/point_table_nearest_bbox_unit.sv =====
`timescale 1ns / 1ps
// Ordered table of up to MAX_POINTS 3D points with append, remove, clear,
// nearest-point search and bounding box. An item is taken when start is high
// and busy is low; its result appears on the result ports for one cycle with
// done high and must be taken then. Add, clear, a remove with a bad index and
// unused codes show done in the next cycle and leave busy low. Nearest and
// bounding box hold busy high while they scan every stored point; a valid
// remove holds busy high while it shifts each entry above entry_index down
// by one. The point memory has one read port, so the scan and the
// shift-down move one entry per cycle; busy drops in the cycle that
// shows done, so the next item can be taken there.
module point_table_nearest_bbox_unit #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  ptnb_pkg::op_t                        operation,
  input  logic signed [COORD_BITS-1:0]         point_x,
  input  logic signed [COORD_BITS-1:0]         point_y,
  input  logic signed [COORD_BITS-1:0]         point_z,
  input  logic [$clog2(MAX_POINTS)-1:0]        entry_index,
  output logic                                 busy,
  output logic                                 done,
  output ptnb_pkg::status_t                    status,
  output logic                                 found,
  output logic [$clog2(MAX_POINTS)-1:0]        nearest_index,
  output logic signed [COORD_BITS-1:0]         box_min_x,
  output logic signed [COORD_BITS-1:0]         box_min_y,
  output logic signed [COORD_BITS-1:0]         box_min_z,
  output logic signed [COORD_BITS-1:0]         box_max_x,
  output logic signed [COORD_BITS-1:0]         box_max_y,
  output logic signed [COORD_BITS-1:0]         box_max_z,
  output logic [$clog2(MAX_POINTS+1)-1:0]      point_count
);

  import ptnb_pkg::*;

  localparam int IdxW  = $clog2(MAX_POINTS);
  localparam int CntW  = $clog2(MAX_POINTS + 1);
  localparam int WordW = 3 * COORD_BITS;
  localparam int SqW   = 2 * COORD_BITS;
  localparam int DistW = SqW + 2;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_POINTS);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT} state_t;

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    abs_diff = d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
  endfunction

  state_t state;
  logic [CntW-1:0] count;
  logic [CntW-1:0] rd_ptr;
  logic [CntW-1:0] scan_end;
  logic            is_near;
  logic signed [COORD_BITS-1:0] q_x, q_y, q_z;

  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [WordW-1:0] wr_data;
  logic             issue;
  logic [WordW-1:0] rd_data;
  logic signed [COORD_BITS-1:0] r_x, r_y, r_z;

  logic            v1, v2, v3, v4;
  logic [IdxW-1:0] idx1, idx2, idx3, idx4;
  logic [COORD_BITS-1:0] ad_x, ad_y, ad_z;
  logic [SqW-1:0]   sq_x, sq_y, sq_z;
  logic [DistW-1:0] sum_sq;
  logic             pipe_empty;

  logic             have;
  logic [DistW-1:0] best_dist;
  logic [IdxW-1:0]  best_idx;
  logic signed [COORD_BITS-1:0] mn_x, mn_y, mn_z, mx_x, mx_y, mx_z;

  assign busy       = (state != S_IDLE);
  assign issue      = (state != S_IDLE) && (rd_ptr < scan_end);
  assign pipe_empty = !issue && !v1 && !v2 && !v3 && !v4;

  assign r_x = rd_data[COORD_BITS-1:0];
  assign r_y = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign r_z = rd_data[3*COORD_BITS-1:2*COORD_BITS];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IdxW-1:0];
    wr_data = {point_z, point_y, point_x};
    if (state == S_IDLE && start && operation == OP_ADD && count < MaxCnt) begin
      wr_en = 1'b1;
    end else if (state == S_SHIFT && v1) begin
      wr_en   = 1'b1;
      wr_addr = IdxW'(idx1 - 1'b1);
      wr_data = rd_data;
    end
  end

  ptnb_ram #(
    .WIDTH(WordW),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (issue),
    .rd_addr(rd_ptr[IdxW-1:0]),
    .rd_data(rd_data)
  );

  // distance pipeline: abs diff, squares, sum
  always_ff @(posedge clk) begin
    idx1 <= rd_ptr[IdxW-1:0];
    idx2 <= idx1;
    idx3 <= idx2;
    idx4 <= idx3;
    ad_x <= abs_diff(r_x, q_x);
    ad_y <= abs_diff(r_y, q_y);
    ad_z <= abs_diff(r_z, q_z);
    sq_x <= SqW'(ad_x) * SqW'(ad_x);
    sq_y <= SqW'(ad_y) * SqW'(ad_y);
    sq_z <= SqW'(ad_z) * SqW'(ad_z);
    sum_sq <= DistW'(sq_x) + DistW'(sq_y) + DistW'(sq_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      rd_ptr      <= '0;
      scan_end    <= '0;
      done        <= 1'b0;
      point_count <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      have        <= 1'b0;
    end else begin
      done <= 1'b0;
      v1   <= issue;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      if (issue) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            done          <= 1'b1;
            status        <= ST_OK;
            found         <= 1'b0;
            nearest_index <= '0;
            box_min_x     <= '0;
            box_min_y     <= '0;
            box_min_z     <= '0;
            box_max_x     <= '0;
            box_max_y     <= '0;
            box_max_z     <= '0;
            point_count   <= count;
            case (operation)
              OP_ADD: begin
                if (count < MaxCnt) begin
                  count       <= count + 1'b1;
                  point_count <= count + 1'b1;
                end else begin
                  status <= ST_FULL;
                end
              end
              OP_REMOVE: begin
                if (CntW'(entry_index) < count) begin
                  state    <= S_SHIFT;
                  rd_ptr   <= CntW'(entry_index) + 1'b1;
                  scan_end <= count;
                  count    <= count - 1'b1;
                  done     <= 1'b0;
                end else begin
                  status <= ST_RANGE;
                end
              end
              OP_CLEAR: begin
                count       <= '0;
                point_count <= '0;
              end
              OP_NEAREST, OP_BBOX: begin
                state     <= S_SCAN;
                rd_ptr    <= '0;
                scan_end  <= count;
                is_near   <= (operation == OP_NEAREST);
                q_x       <= point_x;
                q_y       <= point_y;
                q_z       <= point_z;
                have      <= 1'b0;
                best_idx  <= '0;
                best_dist <= '0;
                mn_x      <= '0;
                mn_y      <= '0;
                mn_z      <= '0;
                mx_x      <= '0;
                mx_y      <= '0;
                mx_z      <= '0;
                done      <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (v1 && !is_near) begin
            if (idx1 == '0 || r_x < mn_x) mn_x <= r_x;
            if (idx1 == '0 || r_y < mn_y) mn_y <= r_y;
            if (idx1 == '0 || r_z < mn_z) mn_z <= r_z;
            if (idx1 == '0 || r_x > mx_x) mx_x <= r_x;
            if (idx1 == '0 || r_y > mx_y) mx_y <= r_y;
            if (idx1 == '0 || r_z > mx_z) mx_z <= r_z;
          end
          if (v4 && is_near && (!have || sum_sq < best_dist)) begin
            have      <= 1'b1;
            best_dist <= sum_sq;
            best_idx  <= idx4;
          end
          if (pipe_empty) begin
            state         <= S_IDLE;
            done          <= 1'b1;
            point_count   <= count;
            found         <= is_near && have;
            nearest_index <= (is_near && have) ? best_idx : '0;
            if (!is_near) begin
              box_min_x <= mn_x;
              box_min_y <= mn_y;
              box_min_z <= mn_z;
              box_max_x <= mx_x;
              box_max_y <= mx_y;
              box_max_z <= mx_z;
            end
          end
        end
        S_SHIFT: begin
          if (pipe_empty) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            point_count <= count;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ptnb_checker.sv =====
`timescale 1ns / 1ps
`include "point_table_nearest_bbox_unit_assert.svh"
module ptnb_checker #(
  parameter int MAX_POINTS = 64
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input ptnb_pkg::op_t                   operation,
  input logic                            done,
  input ptnb_pkg::status_t               status,
  input logic                            found,
  input logic [$clog2(MAX_POINTS)-1:0]   nearest_index,
  input logic [$clog2(MAX_POINTS+1)-1:0] point_count
);

  import ptnb_pkg::*;

  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_POINTS);

  `PTNB_ASSERT_NEXT(a_clear_empties, start && !busy && operation == OP_CLEAR, done && point_count == '0, "clear did not give an empty table")
  `PTNB_ASSERT_SAME(a_full_count, done && status == ST_FULL, point_count == MaxCnt, "full reported on a table that is not full")
  `PTNB_ASSERT_SAME(a_found_in_range, done && found, CntW'(nearest_index) < point_count, "nearest index beyond stored points")
  `PTNB_ASSERT_SAME(a_count_bound, 1'b1, point_count <= MaxCnt, "point count above capacity")

endmodule

bind point_table_nearest_bbox_unit ptnb_checker #(
  .MAX_POINTS(MAX_POINTS)
) u_ptnb_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .operation    (operation),
  .done         (done),
  .status       (status),
  .found        (found),
  .nearest_index(nearest_index),
  .point_count  (point_count)
);

// ===== sim/tb_point_table_nearest_bbox_unit.sv =====
`timescale 1ns / 1ps
module tb_point_table_nearest_bbox_unit;
  import ptnb_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int COORD_W      = 16;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;

  localparam op_t OP_SPARE_FIRST = OP_BBOX + 3'd1;
  localparam op_t OP_SPARE_LAST  = 3'd7;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef struct {
    status_t status;
    logic    found;
    idx_t    near_idx;
    coord_t  min_x, min_y, min_z;
    coord_t  max_x, max_y, max_z;
    cnt_t    count;
  } table_reply_t;

  class point_table_tracker;
    coord_t       tbl_x[TABLE_DEPTH];
    coord_t       tbl_y[TABLE_DEPTH];
    coord_t       tbl_z[TABLE_DEPTH];
    int           fill;
    int           errors;
    int           replies_seen;
    table_reply_t replies_due[$];

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task cmp_field(string fname, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("item %0d %s: got %0h, want %0h",
                                  replies_seen, fname, got, want));
    endtask

    function longint unsigned dist_sq(int i, coord_t qx, coord_t qy, coord_t qz);
      longint dx, dy, dz;
      dx = longint'(tbl_x[i]) - longint'(qx);
      dy = longint'(tbl_y[i]) - longint'(qy);
      dz = longint'(tbl_z[i]) - longint'(qz);
      return dx * dx + dy * dy + dz * dz;
    endfunction

    task take_command(op_t op, coord_t qx, coord_t qy, coord_t qz, idx_t idx);
      table_reply_t    r;
      longint unsigned d, best_d;
      int              i;
      r = '{default: '0};
      r.status = ST_OK;
      best_d = '1;
      case (op)
        OP_ADD: begin
          if (fill >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            tbl_x[fill] = qx;
            tbl_y[fill] = qy;
            tbl_z[fill] = qz;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (int'(idx) >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (i = idx; i + 1 < fill; i++) begin
              tbl_x[i] = tbl_x[i+1];
              tbl_y[i] = tbl_y[i+1];
              tbl_z[i] = tbl_z[i+1];
            end
            fill--;
          end
        end
        OP_CLEAR: fill = 0;
        OP_NEAREST: begin
          for (i = 0; i < fill; i++) begin
            d = dist_sq(i, qx, qy, qz);
            if (!r.found || d < best_d) begin
              r.found = 1'b1;
              best_d = d;
              r.near_idx = idx_t'(i);
            end
          end
        end
        OP_BBOX: begin
          if (fill > 0) begin
            r.min_x = tbl_x[0]; r.min_y = tbl_y[0]; r.min_z = tbl_z[0];
            r.max_x = tbl_x[0]; r.max_y = tbl_y[0]; r.max_z = tbl_z[0];
            for (i = 1; i < fill; i++) begin
              if (tbl_x[i] < r.min_x) r.min_x = tbl_x[i];
              if (tbl_y[i] < r.min_y) r.min_y = tbl_y[i];
              if (tbl_z[i] < r.min_z) r.min_z = tbl_z[i];
              if (tbl_x[i] > r.max_x) r.max_x = tbl_x[i];
              if (tbl_y[i] > r.max_y) r.max_y = tbl_y[i];
              if (tbl_z[i] > r.max_z) r.max_z = tbl_z[i];
            end
          end
        end
        default: ;
      endcase
      r.count = cnt_t'(fill);
      replies_due.push_back(r);
    endtask

    task match_reply(table_reply_t got);
      table_reply_t w;
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("item %0d: result with no item pending", replies_seen));
        return;
      end
      w = replies_due.pop_front();
      cmp_field("status", got.status, w.status);
      cmp_field("found", got.found, w.found);
      cmp_field("nearest_index", got.near_idx, w.near_idx);
      cmp_field("box_min_x", got.min_x, w.min_x);
      cmp_field("box_min_y", got.min_y, w.min_y);
      cmp_field("box_min_z", got.min_z, w.min_z);
      cmp_field("box_max_x", got.max_x, w.max_x);
      cmp_field("box_max_y", got.max_y, w.max_y);
      cmp_field("box_max_z", got.max_z, w.max_z);
      cmp_field("point_count", got.count, w.count);
    endtask
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  op_t     operation;
  coord_t  point_x, point_y, point_z;
  idx_t    entry_index;
  logic    busy;
  logic    done;
  status_t status;
  logic    found;
  idx_t    nearest_index;
  coord_t  box_min_x, box_min_y, box_min_z;
  coord_t  box_max_x, box_max_y, box_max_z;
  cnt_t    point_count;

  point_table_tracker tracker = new();

  point_table_nearest_bbox_unit #(
    .MAX_POINTS(TABLE_DEPTH),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk, .rst, .start, .operation,
    .point_x, .point_y, .point_z, .entry_index,
    .busy, .done, .status, .found, .nearest_index,
    .box_min_x, .box_min_y, .box_min_z,
    .box_max_x, .box_max_y, .box_max_z,
    .point_count
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result of an older item is checked before the item taken at the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        tracker.match_reply('{status: status, found: found, near_idx: nearest_index,
                              min_x: box_min_x, min_y: box_min_y, min_z: box_min_z,
                              max_x: box_max_x, max_y: box_max_y, max_z: box_max_z,
                              count: point_count});
      if (start && !busy)
        tracker.take_command(operation, point_x, point_y, point_z, entry_index);
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return C_MIN;
      1:       return C_MAX;
      2, 3:    return coord_t'($urandom_range(0, 4)) - coord_t'(2);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic op_t pick_op(int mode, int roll);
    int add_lim, rem_lim, near_lim, box_lim, clr_lim;
    case (mode)
      MODE_GROW:   begin add_lim = 80; rem_lim = 84; near_lim = 92; box_lim = 98; end
      MODE_SHRINK: begin add_lim = 15; rem_lim = 60; near_lim = 75; box_lim = 90; end
      default:     begin add_lim = 35; rem_lim = 55; near_lim = 75; box_lim = 92; end
    endcase
    clr_lim = (mode == MODE_GROW) ? box_lim + 1 : box_lim + 3;
    if (roll < add_lim)  return OP_ADD;
    if (roll < rem_lim)  return OP_REMOVE;
    if (roll < near_lim) return OP_NEAREST;
    if (roll < box_lim)  return OP_BBOX;
    if (roll < clr_lim)  return OP_CLEAR;
    return op_t'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
  endfunction

  task automatic send_item(op_t op, coord_t x, coord_t y, coord_t z, idx_t idx);
    start       <= 1'b1;
    operation   <= op;
    point_x     <= x;
    point_y     <= y;
    point_z     <= z;
    entry_index <= idx;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      start       <= 1'b0;
      operation   <= op_t'($urandom);
      point_x     <= coord_t'($urandom);
      point_y     <= coord_t'($urandom);
      point_z     <= coord_t'($urandom);
      entry_index <= idx_t'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    int s;
    send_item(OP_BBOX, '0, '0, '0, '0);
    send_item(OP_NEAREST, C_MIN, C_MAX, C_MIN, '0);
    send_item(OP_REMOVE, '0, '0, '0, '0);
    for (s = OP_SPARE_FIRST; s <= OP_SPARE_LAST; s++)
      send_item(op_t'(s), rand_coord(), rand_coord(), rand_coord(), idx_t'($urandom));
    send_item(OP_ADD, C_MIN, C_MIN, C_MIN, '0);
    send_item(OP_ADD, C_MAX, C_MAX, C_MAX, '1);
    send_item(OP_ADD, '0, '0, '0, '0);
    send_item(OP_ADD, '0, '0, '0, '0);
    send_item(OP_ADD, C_MAX, C_MIN, coord_t'(1), '0);
    // equal distance to entries 2 and 3: lower index wins
    send_item(OP_NEAREST, '0, '0, '0, '0);
    send_item(OP_NEAREST, C_MIN, C_MIN, C_MIN, '0);
    send_item(OP_NEAREST, C_MAX, C_MAX, C_MAX, '0);
    send_item(OP_BBOX, '0, '0, '0, '0);
    idle_gap(3);
    send_item(OP_REMOVE, '0, '0, '0, '1);
    send_item(OP_REMOVE, '0, '0, '0, idx_t'(5));
    send_item(OP_REMOVE, '0, '0, '0, idx_t'(1));
    send_item(OP_REMOVE, '0, '0, '0, idx_t'(3));
    send_item(OP_REMOVE, '0, '0, '0, '0);
    send_item(OP_BBOX, '0, '0, '0, '0);
    send_item(OP_NEAREST, C_MAX, '0, C_MIN, '0);
    send_item(OP_CLEAR, C_MAX, C_MAX, C_MAX, '1);
    send_item(OP_BBOX, '0, '0, '0, '0);
    send_item(OP_NEAREST, '0, '0, '0, '0);
  endtask

  task automatic run_random();
    int     sent, burst, mode, k, j, gap;
    op_t    op;
    coord_t x, y, z;
    idx_t   idx;
    sent  = 0;
    mode  = MODE_GROW;
    burst = 100;  // opening burst runs the table into full
    while (sent < RANDOM_ITEMS) begin
      for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        op  = pick_op(mode, $urandom_range(0, 99));
        x   = rand_coord();
        y   = rand_coord();
        z   = rand_coord();
        idx = idx_t'($urandom);
        if (op == OP_REMOVE && tracker.fill > 0 && $urandom_range(0, 4) != 0)
          idx = idx_t'($urandom_range(0, tracker.fill - 1));
        if (op == OP_NEAREST && tracker.fill > 0 && $urandom_range(0, 1) == 0) begin
          j = $urandom_range(0, tracker.fill - 1);
          x = tracker.tbl_x[j] + coord_t'($urandom_range(0, 2)) - coord_t'(1);
          y = tracker.tbl_y[j];
          z = tracker.tbl_z[j] + coord_t'($urandom_range(0, 2)) - coord_t'(1);
        end
        send_item(op, x, y, z, idx);
        sent++;
      end
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 4);
        2:       gap = $urandom_range(5, 30);
        default: gap = $urandom_range(31, 90);
      endcase
      idle_gap(gap);
      burst = $urandom_range(1, 40);
      mode  = $urandom_range(MODE_GROW, MODE_MIXED);
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    operation   = OP_ADD;
    point_x     = '0;
    point_y     = '0;
    point_z     = '0;
    entry_index = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    start <= 1'b0;
    do @(posedge clk); while (tracker.replies_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ptnb_pkg.sv
rtl/ptnb_ram.sv
rtl/point_table_nearest_bbox_unit.sv
rtl/ptnb_checker.sv
sim/tb_point_table_nearest_bbox_unit.sv
